>>> rtl/sffle_pkg.sv
// ----------------------------------------------------------------------------
// sffle_pkg
// shared types, constants and helpers of the sync flagged packet extractor
// ----------------------------------------------------------------------------
package sffle_pkg;

    localparam int ITEM_W   = 8;    // bits of one stream item
    localparam int HIST_AW  = 6;    // history address bits
    localparam int POS_W    = 7;    // item position counter, wraps at 128
    localparam int LEN_W    = 7;    // packet length register
    localparam int CNT_W    = 7;    // pending start count, holds 0..64
    localparam int MAX_PKT  = 64;   // longest packet and history depth

    localparam logic REG_PKT_LEN = 1'b0;  // register index of packet_length
    localparam logic [LEN_W-1:0] PKT_LEN_RESET = LEN_W'(MAX_PKT);

    // history write from the front part to the history memory
    typedef struct packed {
        logic              en;
        logic [HIST_AW-1:0] addr;
        logic [ITEM_W-1:0]  data;
    } t_hist_wr;

    // one packet to read out of the history
    typedef struct packed {
        logic [HIST_AW-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_job;

    // job queue status
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DROP,
        F_EMIT
    } t_front_state;

    // length as used: zero acts as one, above the maximum acts as the maximum
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] len;
        len = raw;
        if (raw == '0) begin
            len = LEN_W'(1);
        end else if (raw > LEN_W'(MAX_PKT)) begin
            len = LEN_W'(MAX_PKT);
        end
        return len;
    endfunction

endpackage

>>> rtl/sffle_job_queue.sv
// ----------------------------------------------------------------------------
// sffle_job_queue
// two-entry queue of packet jobs between the front and the back part
// ----------------------------------------------------------------------------
module sffle_job_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sffle_pkg::t_job     i_job,
    input  logic                i_pop,
    output sffle_pkg::t_job     o_job,
    output sffle_pkg::t_q_status o_stat
);
    import sffle_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    assign o_job        = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> rtl/sffle_front.sv
// ----------------------------------------------------------------------------
// sffle_front
// accepts items, tracks pending packet starts and issues packet jobs
// ----------------------------------------------------------------------------
module sffle_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sffle_pkg::ITEM_W-1:0]      i_sample,
    input  logic                              i_sync,
    input  logic [sffle_pkg::LEN_W-1:0]       i_len,
    input  sffle_pkg::t_q_status              i_q_stat,
    input  logic                              i_back_busy,
    output sffle_pkg::t_hist_wr               o_hist_wr,
    output logic                              o_job_push,
    output sffle_pkg::t_job                   o_job
);
    import sffle_pkg::*;

    t_front_state       r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [HIST_AW-1:0] r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_sync, n_sync;

    // pending start memory
    logic [POS_W-1:0]   r_pend [MAX_PKT];
    logic [POS_W-1:0]   r_pend_rd;
    logic               pend_re;
    logic [HIST_AW-1:0] pend_ra;
    logic               pend_we;
    logic [HIST_AW-1:0] pend_wa;

    logic [POS_W-1:0]   age_head;
    logic               push_ok;
    logic [CNT_W-1:0]   cnt_push;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   age_start;
    logic               emit;

    assign age_head  = r_pos - r_pend_rd;
    assign push_ok   = r_sync && (r_count != CNT_W'(MAX_PKT));
    assign cnt_push  = r_count + CNT_W'(push_ok);
    assign start     = (r_count == '0) ? r_pos : r_pend_rd;
    assign age_start = r_pos - start;
    assign emit      = (cnt_push != '0) &&
                       (({1'b0, age_start} + (POS_W+1)'(1)) >= {1'b0, i_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pos   <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_sync  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_head  <= n_head;
            r_count <= n_count;
            r_sync  <= n_sync;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend[pend_wa] <= r_pos;
        end
        if (pend_re) begin
            r_pend_rd <= r_pend[pend_ra];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_head         = r_head;
        n_count        = r_count;
        n_sync         = r_sync;
        o_in_ready     = 1'b0;
        o_hist_wr.en   = 1'b0;
        o_hist_wr.addr = r_pos[HIST_AW-1:0];
        o_hist_wr.data = i_sample;
        o_job_push     = 1'b0;
        o_job.start    = start[HIST_AW-1:0];
        o_job.len      = i_len;
        pend_re        = 1'b0;
        pend_ra        = r_head;
        pend_we        = 1'b0;
        pend_wa        = r_head + r_count[HIST_AW-1:0];
        case (r_state)
            F_IDLE: begin
                // wait until no packet readout touches the history
                o_in_ready = i_q_stat.empty && !i_back_busy;
                if (i_in_valid && o_in_ready) begin
                    o_hist_wr.en = 1'b1;
                    n_sync       = i_sync;
                    pend_re      = 1'b1;
                    n_state      = F_DROP;
                end
            end
            F_DROP: begin
                // head start older than the history is dropped
                if ((r_count != '0) && age_head[POS_W-1]) begin
                    n_head  = r_head + HIST_AW'(1);
                    n_count = r_count - CNT_W'(1);
                    pend_re = 1'b1;
                    pend_ra = r_head + HIST_AW'(1);
                end else begin
                    n_state = F_EMIT;
                end
            end
            F_EMIT: begin
                pend_we = push_ok;
                if (emit) begin
                    o_job_push = 1'b1;
                    n_head     = r_head + HIST_AW'(1);
                    n_count    = cnt_push - CNT_W'(1);
                end else begin
                    n_count = cnt_push;
                end
                n_pos   = r_pos + POS_W'(1);
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sffle_back.sv
// ----------------------------------------------------------------------------
// sffle_back
// history memory and packet readout into the output register
// ----------------------------------------------------------------------------
module sffle_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sffle_pkg::t_hist_wr           i_hist_wr,
    input  sffle_pkg::t_q_status          i_q_stat,
    input  sffle_pkg::t_job               i_job,
    output logic                          o_job_pop,
    output logic                          o_busy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sffle_pkg::ITEM_W-1:0]  o_data,
    output logic                          o_first,
    output logic                          o_last
);
    import sffle_pkg::*;

    logic [ITEM_W-1:0]  r_hist [MAX_PKT];
    logic               r_busy;
    logic [HIST_AW-1:0] r_addr;
    logic [LEN_W-1:0]   r_left;
    logic               r_first_pend;
    logic               r_out_valid;
    logic [ITEM_W-1:0]  r_rd_data;
    logic               r_first;
    logic               r_last;
    logic               rd_en;

    // read only when the output register is free or being taken
    assign rd_en     = r_busy && (!r_out_valid || i_ready);
    assign o_job_pop = !r_busy && !i_q_stat.empty;
    assign o_busy    = r_busy;
    assign o_valid   = r_out_valid;
    assign o_data    = r_rd_data;
    assign o_first   = r_first;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_addr       <= '0;
            r_left       <= '0;
            r_first_pend <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_busy       <= 1'b1;
                r_addr       <= i_job.start;
                r_left       <= i_job.len;
                r_first_pend <= 1'b1;
            end else if (rd_en) begin
                r_addr       <= r_addr + HIST_AW'(1);
                r_left       <= r_left - LEN_W'(1);
                r_first_pend <= 1'b0;
                if (r_left == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (rd_en) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hist_wr.en) begin
            r_hist[i_hist_wr.addr] <= i_hist_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[r_addr];
            r_first   <= r_first_pend;
            r_last    <= (r_left == LEN_W'(1));
        end
    end

endmodule

>>> rtl/sync_flagged_fixed_length_extractor.sv
// ----------------------------------------------------------------------------
// sync_flagged_fixed_length_extractor
// extracts fixed-length packets after sync-flagged items from a byte stream
// ----------------------------------------------------------------------------
// path: completing item via front drop and emit states, job queue, back job pop
//   and history read to the output register, a further drop state per stale
//   start, then one item a cycle while output is ready; the front takes an item
//   per idle, drop, emit pass; input holds while history is read for a packet
// reset: synchronous active low, clears control state, packet_length to 64;
//   history and pending-start memories are not cleared
module sync_flagged_fixed_length_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] sample
    input  logic        i_s_axis_tuser,   // [0] sync_mark
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] packet_item
    output logic        o_m_axis_tuser,   // [0] packet_first
    output logic        o_m_axis_tlast,   // packet_last
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import sffle_pkg::*;

    logic [LEN_W-1:0] r_pkt_len;
    logic [LEN_W-1:0] len_used;
    logic             cfg_wr;

    t_hist_wr  hist_wr;
    t_job      job_in;
    t_job      job_out;
    t_q_status q_stat;
    logic      job_push;
    logic      job_pop;
    logic      back_busy;

    // apb register, word index from paddr bit 2
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata = (i_paddr[2] == REG_PKT_LEN) ? {{(32-LEN_W){1'b0}}, r_pkt_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_len <= PKT_LEN_RESET;
        end else if (cfg_wr && (i_paddr[2] == REG_PKT_LEN)) begin
            r_pkt_len <= i_pwdata[LEN_W-1:0];
        end
    end

    // clamp once here, both parts see the length in use
    assign len_used = eff_len(r_pkt_len);

    // front: history writes, pending starts, packet decisions
    sffle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_sample    (i_s_axis_tdata),
        .i_sync      (i_s_axis_tuser),
        .i_len       (len_used),
        .i_q_stat    (q_stat),
        .i_back_busy (back_busy),
        .o_hist_wr   (hist_wr),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // jobs waiting for readout
    sffle_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    // back: history memory and registered output
    sffle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hist_wr (hist_wr),
        .i_q_stat  (q_stat),
        .i_job     (job_out),
        .o_job_pop (job_pop),
        .o_busy    (back_busy),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_first   (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

endmodule

>>> rtl/sffle_checker.sv
// ----------------------------------------------------------------------------
// sffle_checker
// port-level checks of the packet extractor, bound to the top level
// ----------------------------------------------------------------------------
module sffle_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  o_m_axis_tdata,
    input  logic        o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    logic r_want_first;
    logic out_acc;
    logic in_acc;

    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_first <= 1'b1;
        end else if (out_acc) begin
            r_want_first <= o_m_axis_tlast;
        end
    end

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
         $stable(o_m_axis_tlast)))
        else $error("output item changed while stalled");

    // first flag exactly on the item after a last item
    a_first_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_m_axis_tuser == r_want_first))
        else $error("first flag out of place");

    // front sequencer takes no item in the cycle after an accept
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("item accepted while front busy");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sync_flagged_fixed_length_extractor sffle_checker u_sffle_checker (.*);
